[hw/rtl/nlv_pkg.sv]
// shared types, codes and constants of the nmea line validator
package nlv_pkg;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_EMPTY    = 3'd1;
	localparam logic [2:0] ST_TOOLONG  = 3'd2;
	localparam logic [2:0] ST_NODOLLAR = 3'd3;
	localparam logic [2:0] ST_NOSTAR   = 3'd4;
	localparam logic [2:0] ST_TAILLEN  = 3'd5;
	localparam logic [2:0] ST_BADHEX   = 3'd6;
	localparam logic [2:0] ST_MISMATCH = 3'd7;

	// register map
	localparam int          ADDR_W         = 3;
	localparam logic        REG_MAX_LEN    = 1'b0;
	localparam logic [7:0]  MAX_LEN_RESET  = 8'd200;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// character constants
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [2:0] GGA_LEN   = 3'd6;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] c;
		logic       is_lf;
		logic       is_zero;
		logic       is_dollar;
		logic       is_star;
		logic       is_print;
		logic       hex_ok;
		logic [3:0] hex_val;
	} cls_t;

	// one result beat
	typedef struct packed {
		logic [2:0] status;
		logic       is_gga;
		logic [7:0] sum;
		logic [7:0] len;
	} res_t;

	// characters of the "$GPGGA" header
	function automatic logic [7:0] gga_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h24;
			3'd1: r = 8'h47;
			3'd2: r = 8'h50;
			3'd3: r = 8'h47;
			3'd4: r = 8'h47;
			3'd5: r = 8'h41;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/nlv_front.sv]
// input side: accepts bytes and classifies them for the line checker
module nlv_front import nlv_pkg::*; (
	input  logic       push,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output cls_t       q_data
);

	assign q_push = push && !q_full;

	always_comb begin
		q_data = '0;
		q_data.c         = rx_byte;
		q_data.is_lf     = (rx_byte == CH_LF);
		q_data.is_zero   = (rx_byte == 8'h00);
		q_data.is_dollar = (rx_byte == CH_DOLLAR);
		q_data.is_star   = (rx_byte == CH_STAR);
		q_data.is_print  = (rx_byte >= 8'h20) && (rx_byte <= 8'h7E);
		if (rx_byte inside {[8'h30:8'h39]}) begin
			q_data.hex_ok  = 1'b1;
			q_data.hex_val = rx_byte[3:0];
		end else if (rx_byte inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			q_data.hex_ok  = 1'b1;
			q_data.hex_val = rx_byte[3:0] + 4'd9;
		end
	end

endmodule

[hw/rtl/nlv_queue.sv]
// short queue of classified bytes between front and back
module nlv_queue import nlv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t wdata,
	output logic full,
	input  logic pop,
	output logic valid,
	output cls_t rdata
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cls_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	assign full   = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign valid  = (cnt_q != '0);
	assign rdata  = mem_q[rd_q];
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			if (push && !do_pop) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end else if (!push && do_pop) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

endmodule

[hw/rtl/nlv_back.sv]
// line checker: runs the per-line state and buffers result beats
module nlv_back import nlv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] max_len,
	input  logic       q_valid,
	input  cls_t       q_data,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output res_t       res
);

	localparam logic [2:0] PH_DOLLAR   = 3'd0;
	localparam logic [2:0] PH_BODY     = 3'd1;
	localparam logic [2:0] PH_TAIL     = 3'd2;
	localparam logic [2:0] PH_NODOLLAR = 3'd3;
	localparam logic [2:0] PH_NOSTAR   = 3'd4;
	localparam logic [2:0] PH_TAILEND  = 3'd5;

	// line state
	cls_t       held_q;
	logic       held_vld_q;
	logic [7:0] cnt_q;
	logic [2:0] phase_q;
	logic [7:0] xor_q;
	logic [1:0] tcnt_q;
	logic [7:0] tdig_q;
	logic       tbad_q;
	logic [2:0] hdr_q;

	// results of feeding the held byte
	logic [2:0] f_phase;
	logic [7:0] f_xor;
	logic [1:0] f_tcnt;
	logic [7:0] f_tdig;
	logic       f_tbad;
	logic [2:0] f_hdr;
	logic [7:0] idx;
	logic [7:0] cnt_inc;
	logic [2:0] fin_status;

	// result buffer
	res_t       rmem_q [2];
	logic       rwr_q, rrd_q;
	logic [1:0] rcnt_q;
	logic       space;
	logic       res_push;
	res_t       res_data;
	logic       do_pop;
	logic       clear;
	logic       do_feed;

	assign empty  = (rcnt_q == 2'd0);
	assign res    = rmem_q[rrd_q];
	assign do_pop = pop && !empty;
	assign space  = (rcnt_q != 2'd2) || do_pop;
	assign q_pop  = q_valid && space;

	assign idx     = cnt_q - 8'd1;
	assign cnt_inc = (cnt_q == 8'hFF) ? cnt_q : cnt_q + 8'd1;
	assign do_feed = held_vld_q && (cnt_q != 8'd0);

	// feed of the held byte
	always_comb begin
		f_phase = phase_q;
		f_xor   = xor_q;
		f_tcnt  = tcnt_q;
		f_tdig  = tdig_q;
		f_tbad  = tbad_q;
		f_hdr   = hdr_q;
		if (phase_q <= PH_BODY && idx < 8'd6 && {5'b0, hdr_q} == idx
			&& held_q.c == gga_char(idx[2:0])) begin
			f_hdr = hdr_q + 3'd1;
		end
		case (phase_q)
			PH_DOLLAR: begin
				f_phase = held_q.is_dollar ? PH_BODY : PH_NODOLLAR;
			end
			PH_BODY: begin
				if (held_q.is_star) begin
					f_phase = PH_TAIL;
				end else if (!held_q.is_print) begin
					f_phase = PH_NOSTAR;
				end else begin
					f_xor = xor_q ^ held_q.c;
				end
			end
			PH_TAIL: begin
				if (held_q.is_zero) begin
					f_phase = PH_TAILEND;
				end else begin
					if (tcnt_q < 2'd2) begin
						if (!held_q.hex_ok) begin
							f_tbad = 1'b1;
						end else if (tcnt_q == 2'd0) begin
							f_tdig = tdig_q | {held_q.hex_val, 4'h0};
						end else begin
							f_tdig = tdig_q | {4'h0, held_q.hex_val};
						end
					end
					if (tcnt_q != 2'd3) begin
						f_tcnt = tcnt_q + 2'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// status of a line ended by line feed
	always_comb begin
		case (phase_q)
			PH_DOLLAR, PH_NODOLLAR: fin_status = ST_NODOLLAR;
			PH_TAIL, PH_TAILEND: begin
				if (tcnt_q != 2'd2) begin
					fin_status = ST_TAILLEN;
				end else if (tbad_q) begin
					fin_status = ST_BADHEX;
				end else if (tdig_q != xor_q) begin
					fin_status = ST_MISMATCH;
				end else begin
					fin_status = ST_OK;
				end
			end
			default: fin_status = ST_NOSTAR;
		endcase
	end

	always_comb begin
		res_push = 1'b0;
		res_data = '0;
		clear    = 1'b0;
		if (q_pop) begin
			if (q_data.is_lf) begin
				res_push = 1'b1;
				clear    = 1'b1;
				if (cnt_q == 8'd0) begin
					res_data.status = ST_EMPTY;
				end else begin
					res_data.status = fin_status;
					res_data.is_gga = (fin_status == ST_OK) && (hdr_q == GGA_LEN);
					res_data.sum    = xor_q;
					res_data.len    = cnt_q;
				end
			end else if (cnt_inc >= max_len) begin
				res_push        = 1'b1;
				clear           = 1'b1;
				res_data.status = ST_TOOLONG;
				res_data.len    = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rmem_q[rwr_q] <= res_data;
		end
		if (q_pop) begin
			held_q <= clear ? cls_t'(0) : q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			cnt_q      <= '0;
			phase_q    <= PH_DOLLAR;
			xor_q      <= '0;
			tcnt_q     <= '0;
			tdig_q     <= '0;
			tbad_q     <= 1'b0;
			hdr_q      <= '0;
			rwr_q      <= 1'b0;
			rrd_q      <= 1'b0;
			rcnt_q     <= '0;
		end else begin
			if (q_pop) begin
				if (clear) begin
					held_vld_q <= 1'b0;
					cnt_q      <= '0;
					phase_q    <= PH_DOLLAR;
					xor_q      <= '0;
					tcnt_q     <= '0;
					tdig_q     <= '0;
					tbad_q     <= 1'b0;
					hdr_q      <= '0;
				end else begin
					held_vld_q <= 1'b1;
					cnt_q      <= cnt_inc;
					if (do_feed) begin
						phase_q <= f_phase;
						xor_q   <= f_xor;
						tcnt_q  <= f_tcnt;
						tdig_q  <= f_tdig;
						tbad_q  <= f_tbad;
						hdr_q   <= f_hdr;
					end
				end
			end
			if (res_push) begin
				rwr_q <= ~rwr_q;
			end
			if (do_pop) begin
				rrd_q <= ~rrd_q;
			end
			if (res_push && !do_pop) begin
				rcnt_q <= rcnt_q + 2'd1;
			end else if (!res_push && do_pop) begin
				rcnt_q <= rcnt_q - 2'd1;
			end
		end
	end

endmodule

[hw/rtl/nmea_line_validator_core.sv]
// top level of the nmea line validator
// Checks NMEA 0183 sentences in a stream of received bytes, one byte per clock while full is low.
// Bytes are pushed while full is low; a line ends at line feed, and the byte
// before the line feed (the carriage return) is dropped from the check. Each
// line feed gives one result beat, as does a line whose byte count reaches
// max_line_length (status too long, collection restarts). A beat carries the
// status (0 ok, 1 empty, 2 too long, 3 no dollar, 4 no star, 5 tail length,
// 6 bad hex, 7 mismatch), is_gga for a good "$GPGGA" sentence, the XOR of the
// body and the collected length. The front classifies each byte and writes
// it into a four-entry queue in the cycle it is pushed; the back line checker
// takes one byte a cycle from that queue while its result buffer has space,
// and a byte that ends a line writes its result beat into that buffer as the back takes it.
// Sustained rate is one byte per clock while the result side keeps up; the
// two-entry result buffer lets bytes keep flowing while a beat waits for pop,
// and full rises only once the queue fills behind a stalled result side.
// max_line_length lies at byte address 0 of the register port and resets to
// 200; write it only while the block is idle.
module nmea_line_validator_core import nlv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// byte input
	input  logic              push,
	output logic              full,
	input  logic [7:0]        rx_byte,
	// result output
	output logic              empty,
	input  logic              pop,
	output logic [2:0]        status,
	output logic              is_gga,
	output logic [7:0]        computed_sum,
	output logic [7:0]        line_length,
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [7:0] max_len_q;
	logic       q_push;
	cls_t       q_wdata;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	cls_t       q_rdata;
	res_t       res;

	// register port: always ready, one register at word 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MAX_LEN) ? {24'h0, max_len_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[7:0];
		end
	end

	// front: accept and classify
	nlv_front u_front (
		.push    (push),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wdata)
	);

	assign full = q_full;

	// decoupling queue
	nlv_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// back: line checker and result buffer
	nlv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.max_len (max_len_q),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	assign status       = res.status;
	assign is_gga       = res.is_gga;
	assign computed_sum = res.sum;
	assign line_length  = res.len;

endmodule

[dv/nmea_line_validator_core_tb.sv]
// testbench of the nmea line validator core: directed and random lines checked against a predictor
`timescale 1ns / 1ps

module nmea_line_validator_core_tb;
	import nlv_pkg::*;

	// run limits
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_BYTES = 16;
	localparam logic [ADDR_W-1:0] MAX_LEN_ADDR = ADDR_W'(4 * REG_MAX_LEN);
	localparam logic [47:0] GGA_TEXT = "$GPGGA";
	localparam logic [7:0] CH_CR = 8'h0D;

	// where the predictor's sentence check stands
	typedef enum logic [2:0] {
		CK_DOLLAR,
		CK_BODY,
		CK_TAIL,
		CK_NODOLLAR,
		CK_NOSTAR,
		CK_TAILEND
	} chk_e;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  rx_byte = 8'h00;
	logic        pop = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = 32'd0;
	logic        full;
	logic        empty;
	logic [2:0]  status;
	logic        is_gga;
	logic [7:0]  computed_sum;
	logic [7:0]  line_length;
	logic [31:0] prdata;
	logic        pready;

	nmea_line_validator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.rx_byte      (rx_byte),
		.empty        (empty),
		.pop          (pop),
		.status       (status),
		.is_gga       (is_gga),
		.computed_sum (computed_sum),
		.line_length  (line_length),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// predictor state: one line in flight plus the length limit
	logic [7:0] lim_len;
	logic [7:0] held_b;
	logic       held_ok;
	logic [7:0] cnt;
	chk_e       phase;
	logic [7:0] sum_acc;
	logic [1:0] tail_n;
	logic [7:0] tail_v;
	logic       tail_bad;
	logic [2:0] hdr_n;

	// line reports still owed by the block, oldest first
	res_t expected_reports[$];

	int  fault_count = 0;
	int  reports_seen = 0;
	int  cycle_count = 0;
	int  stall_left = 0;
	int  phase_bytes = 0;
	bit  held_once = 1'b0;
	bit  steady = 1'b0;

	// directed table, one row per line
	string row_text[$];
	bit    row_typed[$];
	res_t  row_want[$];

	// length limits walked by the random phases, extremes included
	logic [7:0] lim_plan[$] = '{8'd13, 8'd0, 8'd255, 8'd1, 8'd2, 8'd40, 8'd24, 8'd30};

	function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= "0" && c <= "9") begin
			v = 4'(c - "0");
			return 1'b1;
		end
		if (c >= "A" && c <= "F") begin
			v = 4'(c - "A" + 8'd10);
			return 1'b1;
		end
		if (c >= "a" && c <= "f") begin
			v = 4'(c - "a" + 8'd10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10)
			return "0" + n;
		return (lower ? "a" : "A") + n - 8'd10;
	endfunction

	function automatic void clear_line();
		held_b = 8'd0;
		held_ok = 1'b0;
		cnt = 8'd0;
		phase = CK_DOLLAR;
		sum_acc = 8'd0;
		tail_n = 2'd0;
		tail_v = 8'd0;
		tail_bad = 1'b0;
		hdr_n = 3'd0;
	endfunction

	// one received byte through the line checker; returns 1 when it ends a line
	function automatic bit sentence_step(input logic [7:0] b, output res_t r);
		logic [3:0] nib;
		logic [7:0] c;
		logic [7:0] idx;
		r = '0;
		if (b == CH_LF) begin
			if (cnt != 8'd0) begin
				case (phase)
					CK_DOLLAR, CK_NODOLLAR: r.status = ST_NODOLLAR;
					CK_TAIL, CK_TAILEND: begin
						// length first, then the digits, then the compare
						if (tail_n != 2'd2)
							r.status = ST_TAILLEN;
						else if (tail_bad)
							r.status = ST_BADHEX;
						else if (tail_v != sum_acc)
							r.status = ST_MISMATCH;
						else
							r.status = ST_OK;
					end
					default: r.status = ST_NOSTAR;
				endcase
				r.is_gga = (r.status == ST_OK) && (hdr_n == 3'd6);
				r.sum = sum_acc;
				r.len = cnt;
			end else begin
				r.status = ST_EMPTY;
			end
			clear_line();
			return 1'b1;
		end
		// the held byte is checked only once a later byte shows it was not the last
		if (held_ok && cnt != 8'd0) begin
			c = held_b;
			idx = cnt - 8'd1;
			if ((phase == CK_DOLLAR || phase == CK_BODY) && idx < 8'd6 &&
			    hdr_n == idx[2:0] && c == GGA_TEXT[47 - 8 * idx -: 8])
				hdr_n++;
			case (phase)
				CK_DOLLAR: phase = (c == CH_DOLLAR) ? CK_BODY : CK_NODOLLAR;
				CK_BODY: begin
					if (c == 8'h00)
						phase = CK_NOSTAR;
					else if (c == CH_STAR)
						phase = CK_TAIL;
					else if (c < 8'h20 || c > 8'h7E)
						phase = CK_NOSTAR;
					else
						sum_acc ^= c;
				end
				CK_TAIL: begin
					if (c == 8'h00) begin
						phase = CK_TAILEND;
					end else begin
						if (tail_n < 2'd2) begin
							if (!hex_nibble(c, nib))
								tail_bad = 1'b1;
							else if (tail_n == 2'd0)
								tail_v[7:4] = nib;
							else
								tail_v[3:0] = nib;
						end
						if (tail_n != 2'd3)
							tail_n++;
					end
				end
				default: ;
			endcase
		end
		held_b = b;
		held_ok = 1'b1;
		if (cnt != 8'd255)
			cnt++;
		if (cnt >= lim_len) begin
			r.status = ST_TOOLONG;
			r.len = cnt;
			clear_line();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void add_row(input string s, input bit typed, input res_t want);
		row_text.push_back(s);
		row_typed.push_back(typed);
		row_want.push_back(want);
	endfunction

	// offer one byte after a random gap unless steady; hold it until full reads low, checked at each clock
	task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
		int gap;
		int roll;
		res_t r;
		gap = 0;
		if (!steady) begin
			roll = $urandom_range(0, 99);
			if (roll >= 92)
				gap = $urandom_range(8, 40);
			else if (roll >= 65)
				gap = $urandom_range(1, 3);
		end
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		phase_bytes++;
		if (sentence_step(b, r))
			expected_reports.push_back(typed ? want : r);
	endtask

	// a row's text is literal except for ^HH, which stands for one raw byte
	task automatic send_row(input string s, input bit typed, input res_t want);
		logic [7:0] q[$];
		logic [3:0] hi;
		logic [3:0] lo;
		int i;
		for (i = 0; i < s.len(); i++) begin
			if (s[i] == "^") begin
				void'(hex_nibble(s[i + 1], hi));
				void'(hex_nibble(s[i + 2], lo));
				q.push_back({hi, lo});
				i += 2;
			end else begin
				q.push_back(s[i]);
			end
		end
		foreach (q[j])
			send_byte(q[j], typed && (j == q.size() - 1), want);
	endtask

	// mostly well formed sentences with random content, plus broken ones and noise
	task automatic send_random_line();
		logic [7:0] q[$];
		logic [7:0] sum;
		logic [7:0] ch;
		int kind;
		int n;
		int i;
		int star_at;
		int pick;
		bit lower;
		kind = $urandom_range(0, 99);
		if (kind < 6) begin
			n = $urandom_range(1, 10);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			q.push_back(CH_LF);
		end else if (kind < 9) begin
			q.push_back(CH_LF);
		end else begin
			pick = $urandom_range(0, 27);
			sum = 8'd0;
			q.push_back(CH_DOLLAR);
			if ($urandom_range(0, 2) == 0) begin
				for (i = 1; i < 6; i++) begin
					ch = GGA_TEXT[47 - 8 * i -: 8];
					q.push_back(ch);
					sum ^= ch;
				end
			end
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 14);
			repeat (n) begin
				do
					ch = 8'($urandom_range(32, 126));
				while (ch == CH_STAR);
				q.push_back(ch);
				sum ^= ch;
			end
			star_at = q.size();
			// wrong checksum
			if (pick == 2)
				sum ^= 8'd1 << $urandom_range(0, 7);
			lower = 1'($urandom_range(0, 1));
			q.push_back(CH_STAR);
			q.push_back(hex_char(sum[7:4], lower));
			q.push_back(hex_char(sum[3:0], lower));
			q.push_back(CH_CR);
			q.push_back(CH_LF);
			case (pick)
				// non-hex digit in the tail
				1: q[star_at + $urandom_range(1, 2)] = 8'("G" + $urandom_range(0, 19));
				// one digit short
				3: q.delete(star_at + 1);
				// one digit too many
				4: q.insert(star_at + 1, hex_char(4'($urandom_range(0, 15)), lower));
				// lead character is not a dollar
				5: begin
					do
						ch = 8'($urandom_range(0, 255));
					while (ch == CH_DOLLAR || ch == CH_LF);
					q[0] = ch;
				end
				// control or high byte in the body, possibly over the star
				6: begin
					do
						ch = 8'($urandom_range(0, 255));
					while ((ch >= 8'h20 && ch <= 8'h7E) || ch == CH_LF);
					q[$urandom_range(1, star_at)] = ch;
				end
				// star missing, digits run into the body
				7: q.delete(star_at);
				// no carriage return, so the last digit is dropped instead
				8: q.delete(q.size() - 2);
				// zero byte cuts the sentence short
				9: q[$urandom_range(1, q.size() - 2)] = 8'h00;
				default: ;
			endcase
		end
		foreach (q[j])
			send_byte(q[j], 1'b0, '0);
	endtask

	// pause the sender until every owed report is in, then let queued bytes drain
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// setup beat, then access beat; the register takes the value when pready is high
	task automatic write_max_len(input logic [7:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAX_LEN_ADDR;
		pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		lim_len = v;
	endtask

	// result side: check each popped beat against the oldest owed report, then
	// decide pop for the next cycle (random stalls, one long hold-off)
	always @(posedge clk) begin : report_sink
		res_t got;
		res_t want;
		int roll;
		if (arst_n) begin
			if (pop && !empty) begin
				got = {status, is_gga, computed_sum, line_length};
				reports_seen++;
				if (expected_reports.size() == 0) begin
					if (fault_count < 10)
						$display("unexpected beat: status %0d gga %0d sum %02h len %0d",
							got.status, got.is_gga, got.sum, got.len);
					fault_count++;
				end else begin
					want = expected_reports.pop_front();
					if (got.status !== want.status || got.is_gga !== want.is_gga ||
					    got.sum !== want.sum || got.len !== want.len) begin
						if (fault_count < 10)
							$display("beat %0d: expected st %0d gga %0d sum %02h len %0d, got st %0d gga %0d sum %02h len %0d",
								reports_seen, want.status, want.is_gga, want.sum, want.len,
								got.status, got.is_gga, got.sum, got.len);
						fault_count++;
					end
				end
			end
			// long hold-off once, while the sender keeps pushing, to fill the block
			if (reports_seen == 12 && !held_once) begin
				stall_left = 300;
				held_once = 1'b1;
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
				if (!steady) begin
					roll = $urandom_range(0, 99);
					if (roll < 12)
						stall_left = $urandom_range(1, 3);
					else if (roll < 15)
						stall_left = $urandom_range(10, 50);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("nmea_line_validator_core_tb: errors");
			$finish;
		end
	end

	initial begin : main
		int i;
		int p;
		logic [7:0] ch;
		lim_len = MAX_LEN_RESET;
		clear_line();

		// typed rows are plain enough to read off by hand; the rest go through the predictor
		add_row("^0A", 1'b1, {ST_EMPTY, 1'b0, 8'd0, 8'd0});
		add_row("X^0A", 1'b1, {ST_NODOLLAR, 1'b0, 8'd0, 8'd1});
		add_row("$A*41^0D^0A", 1'b1, {ST_OK, 1'b0, 8'h41, 8'd6});
		add_row("$A*40^0D^0A", 1'b1, {ST_MISMATCH, 1'b0, 8'h41, 8'd6});
		add_row("GPGGA*00^0D^0A", 1'b1, {ST_NODOLLAR, 1'b0, 8'd0, 8'd9});
		add_row("$GPGGA,1,2*55^0D^0A", 1'b0, '0);
		add_row("$GPGGA*56^0D^0A", 1'b0, '0);
		add_row("$GPGGB*55^0D^0A", 1'b0, '0);
		add_row("$GPGG*17^0D^0A", 1'b0, '0);
		add_row("$z*7a^0D^0A", 1'b0, '0);
		add_row("$ ~*5E^0D^0A", 1'b0, '0);
		add_row("$*00^0D^0A", 1'b0, '0);
		add_row("$^0D^0A", 1'b0, '0);
		add_row("$AB^01C*00^0D^0A", 1'b0, '0);
		add_row("$A^7F^FF^0D^0A", 1'b0, '0);
		add_row("$AB^00*03^0D^0A", 1'b0, '0);
		add_row("$A*4^001^0D^0A", 1'b0, '0);
		add_row("$A*4^0D^0A", 1'b0, '0);
		add_row("$A*411^0D^0A", 1'b0, '0);
		add_row("$A*G1^0D^0A", 1'b0, '0);
		add_row("$A*4g^0D^0A", 1'b0, '0);
		add_row("$ABC^0D^0A", 1'b0, '0);
		add_row("$A*41^0A", 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < row_text.size(); i++)
			send_row(row_text[i], row_typed[i], row_want[i]);

		// random phases, each under its own length limit; every third runs with no idling
		for (p = 0; p < lim_plan.size(); p++) begin
			wait_idle();
			steady = (p % 3 == 1);
			write_max_len(lim_plan[p]);
			phase_bytes = 0;
			// one line just past the limit, so the too-long abort always fires
			send_byte(CH_DOLLAR, 1'b0, '0);
			for (i = 0; i < int'(lim_plan[p]) + 2; i++) begin
				ch = 8'($urandom_range(32, 126));
				send_byte(ch, 1'b0, '0);
			end
			send_byte(CH_LF, 1'b0, '0);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES)
				send_random_line();
		end
		steady = 1'b0;

		wait_idle();
		if (fault_count == 0)
			$display("nmea_line_validator_core_tb: clean");
		else
			$display("nmea_line_validator_core_tb: errors");
		$finish;
	end

endmodule
